@@ src/tblf_pkg.sv @@
// Package for the below-level area fraction block: types and constants.
// No dependencies.
`default_nettype none
package tblf_pkg;
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WATER_LEVEL = 3'd0;
endpackage
`default_nettype wire

@@ src/tblf_if.sv @@
// Valid/ready channel interface carrying a parameterised payload.
// Depends on nothing.
`default_nettype none
interface tblf_if #(parameter int unsigned WIDTH = 8);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/tblf_front.sv @@
// Front part: classify triangle, form differences and hold them in a two-entry queue.
// Depends on tblf_pkg.
`default_nettype none
module tblf_front #(
   parameter int unsigned CB = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CB-1:0]       level,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [6*CB-1:0]     in_data,
   output logic                     q_valid,
   input  wire logic                q_ready,
   output logic [3*CB+3:0]          q_data
);
   import tblf_pkg::*;
   localparam int unsigned QW = 3*CB + 4;
   logic [CB-1:0] x [3];
   logic [CB-1:0] y [3];
   logic [CB-1:0] lv;
   logic [CB-1:0] lo, hi, n, d1, d2, bx, by, cx, cy;
   logic [2*CB-1:0] t1, t2;
   logic sbx, sby, scx, scy, s1, s2;
   logic [1:0] head, l1, l2, acnt;
   logic [2:0] ab;
   logic all_above, all_below, deg;
   logic [QW-1:0] item;
   logic [QW-1:0] q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;
   always_comb begin
      lv = level ^ {1'b1, {(CB-1){1'b0}}};
      for (int i = 0; i < 3; i++) begin
         x[i] = in_data[(6-2*i)*CB-1 -: CB] ^ {1'b1, {(CB-1){1'b0}}};
         y[i] = in_data[(5-2*i)*CB-1 -: CB] ^ {1'b1, {(CB-1){1'b0}}};
         ab[i] = y[i] > lv;
      end
      lo = y[0]; hi = y[0];
      for (int i = 1; i < 3; i++) begin
         if (y[i] < lo) lo = y[i];
         if (y[i] > hi) hi = y[i];
      end
      all_above = lo >= lv;
      all_below = hi <= lv;
      sbx = x[1] < x[0]; bx = sbx ? x[0] - x[1] : x[1] - x[0];
      sby = y[1] < y[0]; by = sby ? y[0] - y[1] : y[1] - y[0];
      scx = x[2] < x[0]; cx = scx ? x[0] - x[2] : x[2] - x[0];
      scy = y[2] < y[0]; cy = scy ? y[0] - y[2] : y[2] - y[0];
      t1 = bx * cy;
      t2 = by * cx;
      s1 = (sbx != scy) && (t1 != '0);
      s2 = (sby != scx) && (t2 != '0);
      deg = !all_above && !all_below && (t1 == t2) && (s1 == s2);
      acnt = 2'(ab[0]) + 2'(ab[1]) + 2'(ab[2]);
      head = 2'd0;
      for (int i = 0; i < 3; i++)
         if ((acnt == 2'd1) ? ab[i] : !ab[i]) head = 2'(i);
      l1 = (head == 2'd0) ? 2'd1 : 2'd0;
      l2 = (head == 2'd2) ? 2'd1 : 2'd2;
      n  = (lv >= y[head]) ? lv - y[head] : y[head] - lv;
      d1 = (y[l1] >= y[head]) ? y[l1] - y[head] : y[head] - y[l1];
      d2 = (y[l2] >= y[head]) ? y[l2] - y[head] : y[head] - y[l2];
      item = {all_above, all_below, deg, (acnt == 2'd1), n, d1, d2};
   end
   assign in_ready = cnt_ff != 2'd2;
   assign push = in_valid && in_ready;
   assign pop = q_valid && q_ready;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = q_ff[0];
   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (push && cnt_ff == 2'(pop)) begin
         q_ff[0] <= item;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (push && cnt_ff != 2'(pop)) begin
         q_ff[1] <= item;
      end
   end
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overfill");
   assert property (@(posedge clock) disable iff (reset) (cnt_ff == 2'd2 && !pop) |=> !in_ready)
      else $error("queue full not held");
   assert property (@(posedge clock) disable iff (reset) (cnt_ff == 2'd0) |-> !q_valid)
      else $error("empty queue valid");
endmodule
`default_nettype wire

@@ src/tblf_back.sv @@
// Back part: pipelined multiply and restoring divide producing the ratio.
// Depends on tblf_pkg.
`default_nettype none
module tblf_back #(
   parameter int unsigned CB = 32,
   parameter int unsigned RF = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   output logic                  q_ready,
   input  wire logic [3*CB+3:0]  q_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [RF+1:0]         out_data
);
   import tblf_pkg::*;
   localparam int unsigned NS = RF + 3;
   localparam int unsigned W = 2*CB + 2;
   logic             v_ff [NS];
   logic [W-1:0]     r_ff [NS];
   logic [W-1:0]     r_in [NS];
   logic [W-1:0]     d_ff [NS];
   logic [RF+1:0]    f_ff [NS];
   logic [RF+1:0]    f_in [NS];
   logic [3:0]       c_ff [NS];
   logic [CB-1:0]    n, d1, d2;
   logic             adv;
   logic [W-1:0]     rs;
   logic [RF+1:0]    q, ratio;
   logic [RF+1:0]    one_r;
   assign one_r = (RF+2)'(1) << RF;
   assign adv = !v_ff[NS-1] || out_ready;
   assign q_ready = adv;
   assign {n, d1, d2} = q_data[3*CB-1:0];
   always_comb begin
      r_in[0] = W'(n * n);
      f_in[0] = '0;
      // integer bit of the quotient
      r_in[1] = (r_ff[0] >= d_ff[0]) ? r_ff[0] - d_ff[0] : r_ff[0];
      f_in[1] = (r_ff[0] >= d_ff[0]) ? (RF+2)'(1) : '0;
      rs = '0;
      for (int i = 2; i < NS; i++) begin
         rs = r_ff[i-1] << 1;
         r_in[i] = (rs >= d_ff[i-1]) ? rs - d_ff[i-1] : rs;
         f_in[i] = {f_ff[i-1][RF:0], rs >= d_ff[i-1]};
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= q_valid;
         for (int i = 1; i < NS; i++) v_ff[i] <= v_ff[i-1];
      end
      if (adv) begin
         d_ff[0] <= W'(d1 * d2);
         c_ff[0] <= q_data[3*CB+3:3*CB];
         for (int i = 0; i < NS; i++) begin
            r_ff[i] <= r_in[i];
            f_ff[i] <= f_in[i];
         end
         for (int i = 1; i < NS; i++) begin
            d_ff[i] <= d_ff[i-1];
            c_ff[i] <= c_ff[i-1];
         end
      end
   end
   always_comb begin
      q = (f_ff[NS-1] + (RF+2)'(1)) >> 1;
      if (d_ff[NS-1] == '0) q = '0;
      else if (q > one_r) q = one_r;
      priority if (c_ff[NS-1][3]) ratio = '0;
      else if (c_ff[NS-1][2]) ratio = one_r;
      else if (c_ff[NS-1][1]) ratio = '0;
      else if (c_ff[NS-1][0]) ratio = one_r - q;
      else ratio = q;
   end
   assign out_valid = v_ff[NS-1];
   assign out_data = {ratio[RF:0], c_ff[NS-1][1] && !c_ff[NS-1][3] && !c_ff[NS-1][2]};
   assert property (@(posedge clock) disable iff (reset) out_valid |-> out_data[RF+1:1] <= {1'b1, {RF{1'b0}}})
      else $error("ratio above one");
   assert property (@(posedge clock) disable iff (reset) (out_valid && !out_ready) |=> out_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset) out_data[0] && out_valid |-> out_data[RF+1:1] == '0)
      else $error("degenerate with ratio");
endmodule
`default_nettype wire

@@ src/triangle_below_level_fraction.sv @@
// Top level of the below-level area fraction block.
// Depends on tblf_pkg, tblf_if, tblf_front, tblf_back.
// One triangle per cycle while the result port is not stalled; results pass
// through the front queue, the product stage and the bit-per-stage divider pipeline;
// the level register is written over the APB-style port.
`default_nettype none
module triangle_below_level_fraction #(
   parameter int unsigned COORD_BITS = 32,
   parameter int unsigned RATIO_FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tblf_if.sink      req,
   tblf_if.source    rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [tblf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import tblf_pkg::*;
   localparam int unsigned CB = COORD_BITS;
   logic [CB-1:0] level_ff;
   logic qv, qr;
   logic [3*CB+3:0] qd;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_WATER_LEVEL) ? 32'(level_ff) : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_WATER_LEVEL) begin
         level_ff <= CB'(csr_pwdata);
      end
   end
   tblf_front #(.CB(CB)) u_front (
      .clock(clock), .reset(reset), .level(level_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data[6*CB-1:0]),
      .q_valid(qv), .q_ready(qr), .q_data(qd));
   tblf_back #(.CB(CB), .RF(RATIO_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(qv), .q_ready(qr), .q_data(qd),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule
`default_nettype wire

@@ verif/tblf_checker.sv @@
// Checker for the below-level area fraction block: watches the request, result
// and register ports, predicts each fraction and compares it with the result.
// Depends on tblf_pkg and tblf_if.
`default_nettype none
module tblf_checker (
   input  wire logic clock,
   input  wire logic reset,
   tblf_if           req,
   tblf_if           rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic csr_pready,
   input  wire logic [tblf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int        fail_count,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tblf_pkg::*;

   typedef struct packed {
      logic [16:0] ratio;
      logic        degenerate;
   } fraction_type;

   fraction_type fraction_q[$];
   logic [31:0] level_biased;

   function automatic logic [31:0] diff_mag(input logic [31:0] a, input logic [31:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic fraction_type predict_fraction(input logic [191:0] tri_data,
                                                     input logic [31:0] lvl);
      logic [31:0] x [3];
      logic [31:0] y [3];
      logic [31:0] lo, hi, bx, by, cx, cy, n, d1, d2;
      logic [63:0] t1, t2;
      logic [127:0] num, den, q;
      logic s1, s2;
      int n_above, above, below, head, l1, l2;
      fraction_type f;
      for (int i = 0; i < 3; i++) begin
         x[i] = tri_data[191 - 64*i -: 32] ^ 32'h8000_0000;
         y[i] = tri_data[159 - 64*i -: 32] ^ 32'h8000_0000;
      end
      lo = y[0];
      hi = y[0];
      for (int i = 1; i < 3; i++) begin
         if (y[i] < lo) lo = y[i];
         if (y[i] > hi) hi = y[i];
      end
      f = '0;
      if (lo >= lvl) begin
         f.ratio = 17'd0;
      end else if (hi <= lvl) begin
         f.ratio = 17'h10000;
      end else begin
         bx = diff_mag(x[1], x[0]);
         by = diff_mag(y[1], y[0]);
         cx = diff_mag(x[2], x[0]);
         cy = diff_mag(y[2], y[0]);
         t1 = 64'(bx) * 64'(cy);
         t2 = 64'(by) * 64'(cx);
         s1 = ((x[1] < x[0]) != (y[2] < y[0])) && (t1 != 0);
         s2 = ((y[1] < y[0]) != (x[2] < x[0])) && (t2 != 0);
         n_above = 0;
         above = 0;
         below = 0;
         for (int i = 0; i < 3; i++) begin
            if (y[i] > lvl) begin
               n_above++;
               above = i;
            end else begin
               below = i;
            end
         end
         if (t1 == t2 && s1 == s2) begin
            f.degenerate = 1'b1;
         end else begin
            head = (n_above == 1) ? above : below;
            l1 = (head == 0) ? 1 : 0;
            l2 = (head == 2) ? 1 : 2;
            n = diff_mag(lvl, y[head]);
            d1 = diff_mag(y[l1], y[head]);
            d2 = diff_mag(y[l2], y[head]);
            num = 128'(64'(n) * 64'(n));
            den = 128'(64'(d1) * 64'(d2));
            if (den == 0) q = 0;
            else if (num >= 2 * den) q = 128'h10000;
            else q = ((num << 17) / den + 1) >> 1;
            f.ratio = (n_above == 1) ? 17'(128'h10000 - q) : 17'(q);
         end
      end
      return f;
   endfunction

   assign pending = fraction_q.size();

   always @(posedge clock) begin
      fraction_type want, got;
      if (reset) begin
         fraction_q.delete();
         level_biased <= 32'h8000_0000;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_WATER_LEVEL)
            level_biased <= csr_pwdata ^ 32'h8000_0000;
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (fraction_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = fraction_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: ratio exp %h got %h, degenerate exp %b got %b",
                              want.ratio, got.ratio, want.degenerate, got.degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            fraction_q.push_back(predict_fraction(req.data, level_biased));
      end
   end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Top of the testbench: clock, reset, request stimulus, register writes and
// result back-pressure for triangle_below_level_fraction; verdict from tblf_checker.
// Depends on tblf_pkg, tblf_if, the block and tblf_checker.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tblf_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending;
   int tx_idle_pct = 0, rx_idle_pct = 0, rx_hold = 0;
   logic [31:0] level = 0;

   tblf_if #(.WIDTH(192)) req ();
   tblf_if #(.WIDTH(18)) rsp ();

   triangle_below_level_fraction uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   tblf_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp.ready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   initial begin
      #3ms;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_triangle(input logic [191:0] tri_data);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= tri_data;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (25) @(negedge clock);
   endtask

   task automatic write_level(input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_WATER_LEVEL;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      level = value;
      @(negedge clock);
   endtask

   function automatic logic [31:0] near_level(input int unsigned spread);
      return level + $urandom_range(0, 2 * spread) - spread;
   endfunction

   function automatic logic [191:0] random_triangle();
      logic [191:0] t;
      int unsigned spread;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      spread = (kind < 4) ? 16 : (kind < 8) ? 32'h0010_0000 : 32'h7fff_ffff;
      for (int i = 0; i < 3; i++) begin
         t[191 - 64*i -: 32] = (kind == 9) ? $urandom() : near_level(spread);
         t[159 - 64*i -: 32] = (kind == 9) ? $urandom() : near_level(spread);
      end
      if ($urandom_range(0, 7) == 0) t[159 - 64*$urandom_range(0, 2) -: 32] = level;
      return t;
   endfunction

   initial begin
      logic [31:0] levels [5];
      levels = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0003_8000, 32'hfff0_0000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all above, all below, vertex on the level, collinear, extremes, each lone vertex
      send_triangle({32'h0, 32'h1_0000, 32'h5_0000, 32'h2_0000, 32'h0, 32'h3_0000});
      send_triangle({32'h0, 32'hffff_0000, 32'h5_0000, 32'hfffe_0000, 32'h0, 32'h0});
      send_triangle({32'h0, 32'h0, 32'h4_0000, 32'h0, 32'h0, 32'h4_0000});
      send_triangle({32'h0, 32'hffff_0000, 32'h1_0000, 32'h0, 32'h2_0000, 32'h1_0000});
      send_triangle({32'h0, 32'hffff_0000, 32'h0, 32'h1_0000, 32'h0, 32'h3_0000});
      send_triangle({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff});
      send_triangle({32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000});
      send_triangle({32'h0, 32'h2_0000, 32'h4_0000, 32'hfffe_0000, 32'h0, 32'hffff_0000});
      send_triangle({32'h0, 32'hfffe_0000, 32'h4_0000, 32'h2_0000, 32'h0, 32'h1_0000});
      send_triangle({32'h0, 32'h1_0000, 32'h4_0000, 32'hffff_0000, 32'h2_0000, 32'h3_0000});
      send_triangle({32'h0, 32'hffff_0000, 32'h4_0000, 32'h1_0000, 32'h2_0000, 32'hfffd_0000});
      send_triangle({32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 32'hffff_0000});
      send_triangle({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      send_triangle({32'hffff_ffff, 32'h1, 32'h0, 32'hffff_ffff, 32'h1, 32'h1});
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 86 : 0;
         rx_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 8 : 0;
         for (int l = 0; l < 5; l++) begin
            write_level((l == 4 && phase == 2) ? $urandom() : levels[l]);
            for (int k = 0; k < 42; k++) begin
               if (phase == 2 && l == 1 && k == 5) rx_hold = 200;
               if (phase == 0 && l == 3 && k == 20) begin
                  req.valid <= 1'b0;
                  @(negedge clock);
                  while (pending != 0) @(negedge clock);
               end
               send_triangle(random_triangle());
            end
            drain();
         end
      end
      write_level(32'h0);

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
